>>> rtl/rtty_pkg.sv
// shared types, register codes and constants of the rtty bit serializer
package rtty_pkg;

  localparam int unsigned TickBits    = 24;
  localparam int unsigned FrameBits   = 11;
  localparam int unsigned CharBits    = 8;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 24;

  localparam logic LEVEL_MARK  = 1'b1;
  localparam logic LEVEL_SPACE = 1'b0;

  localparam logic [TickBits-1:0] RESET_BIT_PERIOD = TickBits'(19500);
  localparam logic [3:0]          RESET_DATA_BITS  = 4'd7;
  localparam logic [1:0]          RESET_STOP_BITS  = 2'd2;
  localparam logic [3:0]          MAX_DATA_BITS    = 4'd8;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_BIT_PERIOD = 2'd0,
    REG_DATA_BITS  = 2'd1,
    REG_STOP_BITS  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_CHAR = 1'b1
  } kind_e;

  // effective settings after clamping
  typedef struct packed {
    logic [TickBits-1:0] period;
    logic [3:0]          data_bits;
    logic [3:0]          frame_tail;  // data bits plus stop bits
  } cfg_t;

  typedef struct packed {
    logic                kind;
    logic [CharBits-1:0] char_code;
  } item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
  } result_t;

endpackage

>>> rtl/rtty_ifs.sv
// handshake channel interfaces of the rtty bit serializer

interface rtty_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;
  modport source (output valid, output kind, output char_code, input ready);
  modport sink (input valid, input kind, input char_code, output ready);
endinterface

interface rtty_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;
  modport source (output valid, output line_level, output busy_res, output accepted,
                  input ready);
  modport sink (input valid, input line_level, input busy_res, input accepted,
                output ready);
endinterface

interface rtty_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/rtty_cfg_regs.sv
// configuration registers with clamping of the frame settings
module rtty_cfg_regs
  import rtty_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rtty_cfg_if.sink    cfg_i,
  output cfg_t        cfg_o
);

  logic [TickBits-1:0] period_q;
  logic [3:0]          dbits_q;
  logic [1:0]          sbits_q;
  logic [3:0]          dbits_eff;
  logic [1:0]          sbits_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= RESET_BIT_PERIOD;
      dbits_q  <= RESET_DATA_BITS;
      sbits_q  <= RESET_STOP_BITS;
    end else if (cfg_i.valid) begin
      unique case (reg_idx_e'(cfg_i.index))
        REG_BIT_PERIOD: period_q <= cfg_i.data[TickBits-1:0];
        REG_DATA_BITS:  dbits_q  <= cfg_i.data[3:0];
        REG_STOP_BITS:  sbits_q  <= cfg_i.data[1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_comb begin
    dbits_eff = (dbits_q > MAX_DATA_BITS) ? MAX_DATA_BITS : dbits_q;
    unique case (sbits_q)
      2'd0:    sbits_eff = 2'd1;
      2'd3:    sbits_eff = 2'd2;
      default: sbits_eff = sbits_q;
    endcase
    cfg_o.period     = (period_q == '0) ? TickBits'(1) : period_q;
    cfg_o.data_bits  = dbits_eff;
    cfg_o.frame_tail = dbits_eff + {2'b00, sbits_eff};
  end

endmodule

>>> rtl/rtty_frame_engine.sv
// frame state and one-item update: tick counter, frame shifter, line level
module rtty_frame_engine
  import rtty_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [FrameBits-1:0] frame_q, frame_d;
  logic [3:0]           left_q, left_d;
  logic [TickBits-1:0]  tick_q, tick_d, tick_inc;
  logic                 sending_q, sending_d;
  logic                 level_q, level_d;
  logic                 taken;
  logic [9:0]           ch_ext;
  logic [9:0]           body;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q   <= '1;
      left_q    <= '0;
      tick_q    <= '0;
      sending_q <= 1'b0;
      level_q   <= LEVEL_MARK;
    end else if (step_i) begin
      frame_q   <= frame_d;
      left_q    <= left_d;
      tick_q    <= tick_d;
      sending_q <= sending_d;
      level_q   <= level_d;
    end
  end

  // data bits above the configured count become stop or slack ones
  always_comb begin
    ch_ext = {2'b11, item_i.char_code};
    for (int i = 1; i < FrameBits; i++) begin
      body[i-1] = (4'(i) <= cfg_i.data_bits) ? ch_ext[i-1] : 1'b1;
    end
  end

  assign tick_inc = tick_q + TickBits'(1);

  always_comb begin
    frame_d   = frame_q;
    left_d    = left_q;
    tick_d    = tick_q;
    sending_d = sending_q;
    level_d   = level_q;
    taken     = 1'b0;
    if (item_i.kind == KIND_CHAR) begin
      if (!sending_q) begin
        level_d   = LEVEL_SPACE;
        frame_d   = {1'b1, body};
        left_d    = cfg_i.frame_tail;
        tick_d    = '0;
        sending_d = 1'b1;
        taken     = 1'b1;
      end
    end else if (sending_q) begin
      if (tick_inc >= cfg_i.period) begin
        tick_d = '0;
        if (left_q == 4'd0) begin
          sending_d = 1'b0;
          level_d   = LEVEL_MARK;
        end else begin
          level_d = frame_q[0];
          frame_d = {1'b1, frame_q[FrameBits-1:1]};
          left_d  = left_q - 4'd1;
        end
      end else begin
        tick_d = tick_inc;
      end
    end
  end

  assign res_o.line_level = level_d;
  assign res_o.busy_res   = sending_d;
  assign res_o.accepted   = taken;

endmodule

>>> rtl/rtty_bit_serializer_top.sv
// top level of the rtty bit serializer: input register, frame engine, result register
//
//   channel  dir  handshake       payload
//   in_i     in   valid / ready   kind, char_code
//   out_o    out  valid / ready   line_level, busy_res, accepted
//   cfg_i    in   valid / ready   index (0 period, 1 data bits, 2 stop bits), data
//
// one item per clock sustained while out_o is ready; an item's result reaches out_o through
// the input register, then the frame engine update into the result register
// the frame state advances only when an item moves into the result register
// a stalled result holds; the input register keeps taking items as long as the result
// register frees up in the same cycle
// reset: 19500 ticks per bit, 7 data bits, 2 stop bits, line at mark, not busy
module rtty_bit_serializer_top
  import rtty_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rtty_in_if.sink    in_i,
  rtty_out_if.source out_o,
  rtty_cfg_if.sink   cfg_i
);

  logic    in_valid_q;
  item_t   in_item_q;
  logic    out_valid_q;
  result_t out_res_q;
  logic    advance;
  cfg_t    cfg;
  result_t eng_res;

  // item moves from the input register into the result register
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.kind      <= in_i.kind;
      in_item_q.char_code <= in_i.char_code;
    end
  end

  rtty_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rtty_frame_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (eng_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= eng_res;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.line_level = out_res_q.line_level;
  assign out_o.busy_res   = out_res_q.busy_res;
  assign out_o.accepted   = out_res_q.accepted;

  // a taken character starts a frame with the start bit on the line
  a_taken_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.accepted |-> out_o.busy_res && out_o.line_level == LEVEL_SPACE)
    else $error("taken character without start bit");

  // an idle line rests at mark
  a_idle_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.busy_res |-> out_o.line_level == LEVEL_MARK)
    else $error("idle line not at mark");

  // a stalled result with a full input register blocks new items
  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready && in_valid_q |-> !in_i.ready)
    else $error("input taken while both stages are stalled");

  // a tick item never takes a character
  a_tick_not_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_item_q.kind == KIND_TICK |=> !out_res_q.accepted)
    else $error("tick item flagged as taken");

endmodule
